FILE: rtl/core/ookd_pkg.sv
// Shared types, constants and helper functions for the OOK pulse train decoder.
`timescale 1ns / 1ps

package ookd_pkg;

   // Field widths
   localparam int DUR_W   = 16;
   localparam int TOL_W   = 7;
   localparam int CODE_W  = 32;
   localparam int CNT_W   = 6;
   localparam int IDX_W   = 3;
   localparam int WDATA_W = 16;

   // Durations are compared scaled by 100, so no divider is needed
   localparam int DUR_SCALE = 100;
   localparam int FACT_W    = 8;
   localparam int PROD_W    = DUR_W + FACT_W;

   // Bit limit of a frame; the counter saturates the usable limit at its maximum
   localparam int MAX_BITS       = 32;
   localparam int CNT_MAX        = (1 << CNT_W) - 1;
   localparam int BIT_LIMIT      = (MAX_BITS > CNT_MAX) ? CNT_MAX : MAX_BITS;
   localparam int MIN_VALID_BITS = 8;

   // Register indexes; the six timing registers also index the bound arrays
   localparam logic [IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
   localparam logic [IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
   localparam logic [IDX_W-1:0] REG_ZERO_FIRST  = 3'd2;
   localparam logic [IDX_W-1:0] REG_ZERO_SECOND = 3'd3;
   localparam logic [IDX_W-1:0] REG_ONE_FIRST   = 3'd4;
   localparam logic [IDX_W-1:0] REG_ONE_SECOND  = 3'd5;
   localparam logic [IDX_W-1:0] REG_INVERT      = 3'd6;
   localparam logic [IDX_W-1:0] REG_TOLERANCE   = 3'd7;
   localparam int               NUM_NOM         = 6;

   // Register reset values
   localparam logic [DUR_W-1:0] RST_SYNC_FIRST  = 16'd350;
   localparam logic [DUR_W-1:0] RST_SYNC_SECOND = 16'd10850;
   localparam logic [DUR_W-1:0] RST_ZERO_FIRST  = 16'd350;
   localparam logic [DUR_W-1:0] RST_ZERO_SECOND = 16'd1050;
   localparam logic [DUR_W-1:0] RST_ONE_FIRST   = 16'd1050;
   localparam logic [DUR_W-1:0] RST_ONE_SECOND  = 16'd350;
   localparam logic [TOL_W-1:0] RST_TOLERANCE   = 7'd25;

   // Scaled match windows for each nominal, plus the level polarity
   typedef struct packed {
      logic [NUM_NOM-1:0][PROD_W-1:0] lo;
      logic [NUM_NOM-1:0][PROD_W-1:0] hi;
      logic                           invert;
   } bounds_type;

   // Duration times 100, built from shifts and adds
   function automatic logic [PROD_W-1:0] scale_dur(input logic [DUR_W-1:0] d);
      logic [PROD_W-1:0] dw;
      dw = PROD_W'(d);
      return (dw << 6) + (dw << 5) + (dw << 2);
   endfunction

   // floor(lo/100) <= d  <=>  100d + 99 >= lo ;  d <= floor(hi/100)  <=>  100d <= hi
   function automatic logic dur_match(input logic [PROD_W-1:0] d100,
                                      input logic [PROD_W-1:0] lo,
                                      input logic [PROD_W-1:0] hi);
      logic [PROD_W:0] up;
      up = {1'b0, d100} + (PROD_W+1)'(DUR_SCALE - 1);
      return (up >= {1'b0, lo}) && (d100 <= hi);
   endfunction

endpackage

FILE: rtl/core/ookd_req_if.sv
// Pulse input channel: valid/ready handshake with one pulse per item.
`timescale 1ns / 1ps

interface ookd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       level;
   logic [ookd_pkg::DUR_W-1:0] duration_us;
   logic                       frame_end;

   modport source (output valid, output level, output duration_us, output frame_end,
                   input ready);
   modport sink   (input valid, input level, input duration_us, input frame_end,
                   output ready);
endinterface

FILE: rtl/core/ookd_rsp_if.sv
// Decoded frame result channel: valid/ready handshake with one frame per item.
`timescale 1ns / 1ps

interface ookd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        valid_res;
   logic [ookd_pkg::CODE_W-1:0] code;
   logic [ookd_pkg::CNT_W-1:0]  bit_count;

   modport source (output valid, output valid_res, output code, output bit_count,
                   input ready);
   modport sink   (input valid, input valid_res, input code, input bit_count,
                   output ready);
endinterface

FILE: rtl/core/ook_pulse_train_decoder_core.sv
// Flow: a pulse waits in the input register until it is decoded into the frame state; a frame
// result enters the result register when its last pulse is decoded, and holds until taken.
// Throughput: one pulse per cycle via the single decode stage, stalled while a result waits.
// A register write reaches the match windows through the registered products.
// Reset (synchronous, active high) loads register defaults and clears frame state.
`timescale 1ns / 1ps

module ook_pulse_train_decoder_core (
   input  logic                         clock,
   input  logic                         reset,
   ookd_req_if.sink                     req_chan,
   ookd_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic [ookd_pkg::IDX_W-1:0]   csr_index,
   input  logic [ookd_pkg::WDATA_W-1:0] csr_wdata
);

   ookd_pkg::bounds_type bounds;

   // Registers and match windows
   ookd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .bounds    (bounds)
   );

   // Pulse pairing and frame decode
   ookd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .bounds   (bounds),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: rtl/core/ookd_csr.sv
// Configuration registers and the registered scaled match windows derived from them.
`timescale 1ns / 1ps

module ookd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ookd_pkg::IDX_W-1:0]     csr_index,
   input  logic [ookd_pkg::WDATA_W-1:0]   csr_wdata,
   output ookd_pkg::bounds_type           bounds
);

   logic [ookd_pkg::NUM_NOM-1:0][ookd_pkg::DUR_W-1:0]  nom_ff;
   logic                                               invert_ff;
   logic [ookd_pkg::TOL_W-1:0]                         tol_ff;
   logic [ookd_pkg::NUM_NOM-1:0][ookd_pkg::PROD_W-1:0] lo_ff, lo_in;
   logic [ookd_pkg::NUM_NOM-1:0][ookd_pkg::PROD_W-1:0] hi_ff, hi_in;
   logic [ookd_pkg::FACT_W-1:0]                        fact_lo, fact_hi;
   logic                                               tol_wide;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         nom_ff[ookd_pkg::REG_SYNC_FIRST]  <= ookd_pkg::RST_SYNC_FIRST;
         nom_ff[ookd_pkg::REG_SYNC_SECOND] <= ookd_pkg::RST_SYNC_SECOND;
         nom_ff[ookd_pkg::REG_ZERO_FIRST]  <= ookd_pkg::RST_ZERO_FIRST;
         nom_ff[ookd_pkg::REG_ZERO_SECOND] <= ookd_pkg::RST_ZERO_SECOND;
         nom_ff[ookd_pkg::REG_ONE_FIRST]   <= ookd_pkg::RST_ONE_FIRST;
         nom_ff[ookd_pkg::REG_ONE_SECOND]  <= ookd_pkg::RST_ONE_SECOND;
         invert_ff                         <= 1'b0;
         tol_ff                            <= ookd_pkg::RST_TOLERANCE;
      end else if (csr_we) begin
         case (csr_index)
            ookd_pkg::REG_SYNC_FIRST:  nom_ff[ookd_pkg::REG_SYNC_FIRST]  <= csr_wdata;
            ookd_pkg::REG_SYNC_SECOND: nom_ff[ookd_pkg::REG_SYNC_SECOND] <= csr_wdata;
            ookd_pkg::REG_ZERO_FIRST:  nom_ff[ookd_pkg::REG_ZERO_FIRST]  <= csr_wdata;
            ookd_pkg::REG_ZERO_SECOND: nom_ff[ookd_pkg::REG_ZERO_SECOND] <= csr_wdata;
            ookd_pkg::REG_ONE_FIRST:   nom_ff[ookd_pkg::REG_ONE_FIRST]   <= csr_wdata;
            ookd_pkg::REG_ONE_SECOND:  nom_ff[ookd_pkg::REG_ONE_SECOND]  <= csr_wdata;
            ookd_pkg::REG_INVERT:      invert_ff <= csr_wdata[0];
            ookd_pkg::REG_TOLERANCE:   tol_ff    <= csr_wdata[ookd_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Window factors: (100 - t) floored at zero, and (100 + t)
   assign tol_wide = (ookd_pkg::FACT_W'(tol_ff) >= ookd_pkg::FACT_W'(ookd_pkg::DUR_SCALE));
   assign fact_lo  = tol_wide ? '0 :
                     ookd_pkg::FACT_W'(ookd_pkg::DUR_SCALE) - ookd_pkg::FACT_W'(tol_ff);
   assign fact_hi  = ookd_pkg::FACT_W'(ookd_pkg::DUR_SCALE) + ookd_pkg::FACT_W'(tol_ff);

   // One product per window edge, registered
   always_comb begin
      for (int i = 0; i < ookd_pkg::NUM_NOM; i++) begin
         lo_in[i] = ookd_pkg::PROD_W'(nom_ff[i]) * ookd_pkg::PROD_W'(fact_lo);
         hi_in[i] = ookd_pkg::PROD_W'(nom_ff[i]) * ookd_pkg::PROD_W'(fact_hi);
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign bounds.lo     = lo_ff;
   assign bounds.hi     = hi_ff;
   assign bounds.invert = invert_ff;

endmodule

FILE: rtl/core/ookd_decode.sv
// Pulse input register, pair matching and frame state, and the result register.
`timescale 1ns / 1ps

module ookd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  ookd_pkg::bounds_type bounds,
   ookd_req_if.sink             req_chan,
   ookd_rsp_if.source           rsp_chan
);

   // Input register
   logic                          in_v_ff;
   logic                          in_level_ff;
   logic [ookd_pkg::PROD_W-1:0]   in_d100_ff;
   logic                          in_last_ff;

   // Frame state
   logic                          second_ff, second_in;
   logic                          held_level_ff, held_level_in;
   logic [ookd_pkg::PROD_W-1:0]   held_d100_ff, held_d100_in;
   logic [ookd_pkg::CODE_W-1:0]   shift_ff, shift_in;
   logic [ookd_pkg::CNT_W-1:0]    bits_ff, bits_in;
   logic                          start_ff, start_in;
   logic                          stopped_ff, stopped_in;

   // Result register
   logic                          out_v_ff;
   logic                          out_res_ff;
   logic [ookd_pkg::CODE_W-1:0]   out_code_ff;
   logic [ookd_pkg::CNT_W-1:0]    out_cnt_ff;

   logic                          advance;
   logic                          want1;
   logic                          levels_ok;
   logic                          sync_ok, zero_ok, one_ok;
   logic                          accept;

   assign advance        = in_v_ff && (!out_v_ff || rsp_chan.ready);
   assign req_chan.ready = !in_v_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // Capture the pulse with its duration already scaled
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_level_ff <= req_chan.level;
         in_d100_ff  <= ookd_pkg::scale_dur(req_chan.duration_us);
         in_last_ff  <= req_chan.frame_end;
      end
   end

   // Pair checks against the current windows
   assign want1     = ~bounds.invert;
   assign levels_ok = (held_level_ff == want1) && (in_level_ff == ~want1);
   assign sync_ok   = levels_ok &&
      ookd_pkg::dur_match(held_d100_ff, bounds.lo[ookd_pkg::REG_SYNC_FIRST],
                          bounds.hi[ookd_pkg::REG_SYNC_FIRST]) &&
      ookd_pkg::dur_match(in_d100_ff, bounds.lo[ookd_pkg::REG_SYNC_SECOND],
                          bounds.hi[ookd_pkg::REG_SYNC_SECOND]);
   assign zero_ok   = levels_ok &&
      ookd_pkg::dur_match(held_d100_ff, bounds.lo[ookd_pkg::REG_ZERO_FIRST],
                          bounds.hi[ookd_pkg::REG_ZERO_FIRST]) &&
      ookd_pkg::dur_match(in_d100_ff, bounds.lo[ookd_pkg::REG_ZERO_SECOND],
                          bounds.hi[ookd_pkg::REG_ZERO_SECOND]);
   assign one_ok    = levels_ok &&
      ookd_pkg::dur_match(held_d100_ff, bounds.lo[ookd_pkg::REG_ONE_FIRST],
                          bounds.hi[ookd_pkg::REG_ONE_FIRST]) &&
      ookd_pkg::dur_match(in_d100_ff, bounds.lo[ookd_pkg::REG_ONE_SECOND],
                          bounds.hi[ookd_pkg::REG_ONE_SECOND]);

   // Next frame state for the pulse in the input register
   always_comb begin
      second_in     = second_ff;
      held_level_in = held_level_ff;
      held_d100_in  = held_d100_ff;
      shift_in      = shift_ff;
      bits_in       = bits_ff;
      start_in      = start_ff;
      stopped_in    = stopped_ff;
      if (!second_ff) begin
         held_level_in = in_level_ff;
         held_d100_in  = in_d100_ff;
         second_in     = 1'b1;
      end else begin
         second_in = 1'b0;
         start_in  = 1'b0;
         // a sync pair at frame start is skipped
         if (!(start_ff && sync_ok) && !stopped_ff) begin
            if (zero_ok) begin
               shift_in = {shift_ff[ookd_pkg::CODE_W-2:0], 1'b0};
               bits_in  = bits_ff + 1'b1;
            end else if (one_ok) begin
               shift_in = {shift_ff[ookd_pkg::CODE_W-2:0], 1'b1};
               bits_in  = bits_ff + 1'b1;
            end else begin
               stopped_in = 1'b1;
            end
            if (bits_in >= ookd_pkg::CNT_W'(ookd_pkg::BIT_LIMIT)) begin
               stopped_in = 1'b1;
            end
         end
      end
   end

   // Frame state update; a frame end returns it to the idle frame
   always_ff @(posedge clock) begin
      if (reset || (advance && in_last_ff)) begin
         second_ff     <= 1'b0;
         held_level_ff <= 1'b0;
         held_d100_ff  <= '0;
         shift_ff      <= '0;
         bits_ff       <= '0;
         start_ff      <= 1'b1;
         stopped_ff    <= 1'b0;
      end else if (advance) begin
         second_ff     <= second_in;
         held_level_ff <= held_level_in;
         held_d100_ff  <= held_d100_in;
         shift_ff      <= shift_in;
         bits_ff       <= bits_in;
         start_ff      <= start_in;
         stopped_ff    <= stopped_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= in_last_ff;
      end else if (rsp_chan.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_res_ff  <= (bits_in >= ookd_pkg::CNT_W'(ookd_pkg::MIN_VALID_BITS));
         out_code_ff <= shift_in;
         out_cnt_ff  <= bits_in;
      end
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.valid_res = out_res_ff;
   assign rsp_chan.code      = out_code_ff;
   assign rsp_chan.bit_count = out_cnt_ff;

   // Checks
   a_bits_limit: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= ookd_pkg::CNT_W'(ookd_pkg::BIT_LIMIT))
      else $error("bit counter passed the frame limit");

   a_res_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.valid_res ==
          (rsp_chan.bit_count >= ookd_pkg::CNT_W'(ookd_pkg::MIN_VALID_BITS))))
      else $error("valid flag disagrees with bit count");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=>
         (bits_ff == '0 && start_ff && !second_ff && !stopped_ff))
      else $error("frame state not cleared after frame end");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_v_ff && out_v_ff && !rsp_chan.ready))
      else $error("input stalled without a blocked result");

endmodule
